// ----- hw/rtl/hrbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hrbd_pkg
// Shared types and constants for the heart rate beat detector.
// ----------------------------------------------------------------------------
package hrbd_pkg;

    localparam int RING_BEATS = 5;
    localparam int SLOT_W     = (RING_BEATS > 1) ? $clog2(RING_BEATS) : 1;
    localparam int FILL_W     = $clog2(RING_BEATS + 1);

    localparam int TIME_W     = 32;
    localparam int SAMPLE_W   = 10;
    localparam int REFR_W     = 16;
    localparam int BOUND_W    = 8;
    localparam int TENTHS_W   = 20;
    localparam int CLASS_W    = 2;
    localparam int PROD_W     = BOUND_W + TIME_W;
    localparam int DVD_W      = TIME_W + 1;
    localparam int DCNT_W     = $clog2(DVD_W + 1);

    localparam logic [PROD_W-1:0]   BPM_NUM    = PROD_W'(60000 * (RING_BEATS - 1));
    localparam logic [DVD_W-1:0]    TENTHS_NUM = DVD_W'(600000 * (RING_BEATS - 1));
    localparam logic [TENTHS_W-1:0] TENTHS_MAX = TENTHS_W'(600000);

    localparam logic [SAMPLE_W-1:0] THRESH_RST = SAMPLE_W'(600);
    localparam logic [REFR_W-1:0]   REFR_RST   = REFR_W'(300);
    localparam logic [BOUND_W-1:0]  LO_RST     = BOUND_W'(60);
    localparam logic [BOUND_W-1:0]  HI_RST     = BOUND_W'(100);

    typedef enum logic [1:0] {
        REG_THRESH = 2'd0,
        REG_REFR   = 2'd1,
        REG_LO     = 2'd2,
        REG_HI     = 2'd3
    } t_reg_idx;

    typedef enum logic [CLASS_W-1:0] {
        CLS_NORMAL = 2'd0,
        CLS_LOW    = 2'd1,
        CLS_HIGH   = 2'd2
    } t_rate_class;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SPAN,
        ST_MUL,
        ST_DIV,
        ST_RES,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic ram_re;
        logic div_start;
        logic in_ready;
        logic out_load;
    } t_ctrl;

endpackage

// ----- hw/rtl/hrbd_ram.sv -----
// ----------------------------------------------------------------------------
// hrbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hrbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 5
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- hw/rtl/hrbd_div.sv -----
// ----------------------------------------------------------------------------
// hrbd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrbd_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [hrbd_pkg::DVD_W-1:0]          i_dividend,
    input  logic [hrbd_pkg::TIME_W-1:0]         i_divisor,
    output logic                                o_done,
    output logic [hrbd_pkg::DVD_W-1:0]          o_quot
);

    logic                               r_busy;
    logic [hrbd_pkg::DCNT_W-1:0]        r_cnt;
    logic [hrbd_pkg::TIME_W-1:0]        r_rem;
    logic [hrbd_pkg::TIME_W-1:0]        r_dvs;
    logic [hrbd_pkg::DVD_W-1:0]         r_quo;
    logic                               r_done;

    logic [hrbd_pkg::TIME_W:0]          shifted;
    logic [hrbd_pkg::TIME_W:0]          diff;
    logic                               ge;

    assign shifted = {r_rem, r_quo[hrbd_pkg::DVD_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign ge      = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy &&
                      (r_cnt == hrbd_pkg::DCNT_W'(hrbd_pkg::DVD_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == hrbd_pkg::DCNT_W'(hrbd_pkg::DVD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[hrbd_pkg::TIME_W-1:0] : shifted[hrbd_pkg::TIME_W-1:0];
            r_quo <= {r_quo[hrbd_pkg::DVD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ----- hw/rtl/heart_rate_beat_detector_unit.sv -----
// ----------------------------------------------------------------------------
// heart_rate_beat_detector_unit
// Threshold-crossing beat detector with a ring of beat times in RAM and an
// iterative divider for the rate in tenths of beats per minute.
// ----------------------------------------------------------------------------
// Sequence: before the ring is full a request goes straight to the output register; once
//   full it passes RAM read, span, multiply, 33-step divide and result, with no divide for a zero span.
// Throughput: one request in processing; a new request is taken only once the previous
//   result is loaded into the output register, so any output stall also holds the input.
// Reset: synchronous active-low; control, LEDs and registers to defaults,
//   ring contents are left as they are and are read only once written.
module heart_rate_beat_detector_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // sample[9:0], now_ms[41:10], zero pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // rate_valid[0], rate_tenths[20:1],
                                          // rate_class[22:21], beat_accepted[23],
                                          // green_on[24], red_on[25], zero pad
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    hrbd_pkg::t_state                   r_state, n_state;
    hrbd_pkg::t_ctrl                    ctrl;

    logic [hrbd_pkg::SAMPLE_W-1:0]      r_thresh;
    logic [hrbd_pkg::REFR_W-1:0]        r_refr;
    logic [hrbd_pkg::BOUND_W-1:0]       r_lo;
    logic [hrbd_pkg::BOUND_W-1:0]       r_hi;

    logic [hrbd_pkg::SLOT_W-1:0]        r_write_slot;
    logic [hrbd_pkg::FILL_W-1:0]        r_fill;
    logic [hrbd_pkg::TIME_W-1:0]        r_last;
    logic                               r_above;
    logic [1:0]                         r_led;

    logic [hrbd_pkg::TIME_W-1:0]        r_span;
    logic [hrbd_pkg::PROD_W-1:0]        r_lo_prod;
    logic [hrbd_pkg::PROD_W-1:0]        r_hi_prod;

    logic                               r_res_valid;
    logic [hrbd_pkg::TENTHS_W-1:0]      r_res_tenths;
    hrbd_pkg::t_rate_class              r_res_cls;
    logic                               r_res_acc;

    logic                               r_out_valid;
    logic [31:0]                        r_out_data;

    logic [hrbd_pkg::SAMPLE_W-1:0]      in_sample;
    logic [hrbd_pkg::TIME_W-1:0]        in_now;
    logic                               in_fire;
    logic                               is_above;
    logic [hrbd_pkg::TIME_W-1:0]        since;
    logic                               beat_ok;
    logic [hrbd_pkg::SLOT_W-1:0]        slot_next;
    logic [hrbd_pkg::FILL_W-1:0]        fill_next;

    logic [hrbd_pkg::TIME_W-1:0]        ram_q;
    logic                               div_done;
    logic [hrbd_pkg::DVD_W-1:0]         div_quot;
    logic [hrbd_pkg::DVD_W-1:0]         dividend;
    logic [hrbd_pkg::TENTHS_W-1:0]      tenths_sat;
    hrbd_pkg::t_rate_class              cls;

    logic                               cfg_wr;

    assign in_sample = i_s_axis_tdata[9:0];
    assign in_now    = i_s_axis_tdata[41:10];
    assign in_fire   = i_s_axis_tvalid && ctrl.in_ready;

    assign is_above  = in_sample > r_thresh;
    assign since     = in_now - r_last;
    assign beat_ok   = is_above && !r_above && (since > {16'd0, r_refr});
    assign slot_next = (r_write_slot == hrbd_pkg::SLOT_W'(hrbd_pkg::RING_BEATS - 1))
                       ? '0 : r_write_slot + 1'b1;
    assign fill_next = (beat_ok && r_fill < hrbd_pkg::FILL_W'(hrbd_pkg::RING_BEATS))
                       ? r_fill + 1'b1 : r_fill;

    hrbd_ram #(
        .WIDTH (hrbd_pkg::TIME_W),
        .DEPTH (hrbd_pkg::RING_BEATS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_fire && beat_ok),
        .i_waddr (r_write_slot),
        .i_wdata (in_now),
        .i_re    (ctrl.ram_re),
        .i_raddr (r_write_slot),
        .o_rdata (ram_q)
    );

    assign dividend = hrbd_pkg::TENTHS_NUM + {2'b00, r_span[hrbd_pkg::TIME_W-1:1]};

    hrbd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctrl.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_span),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // rate and class, exact compare of bound*span against the bpm numerator for a nonzero span
    always_comb begin
        if (r_span == '0) begin
            tenths_sat = '0;
            cls        = (r_lo == '0) ? hrbd_pkg::CLS_NORMAL : hrbd_pkg::CLS_LOW;
        end else begin
            tenths_sat = (div_quot > hrbd_pkg::DVD_W'(hrbd_pkg::TENTHS_MAX))
                         ? hrbd_pkg::TENTHS_MAX : div_quot[hrbd_pkg::TENTHS_W-1:0];
            priority if (r_lo_prod > hrbd_pkg::BPM_NUM) begin
                cls = hrbd_pkg::CLS_LOW;
            end else if (hrbd_pkg::BPM_NUM > r_hi_prod) begin
                cls = hrbd_pkg::CLS_HIGH;
            end else begin
                cls = hrbd_pkg::CLS_NORMAL;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hrbd_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = (fill_next >= hrbd_pkg::FILL_W'(hrbd_pkg::RING_BEATS))
                              ? hrbd_pkg::ST_READ : hrbd_pkg::ST_OUT;
                end
            end
            hrbd_pkg::ST_READ: n_state = hrbd_pkg::ST_SPAN;
            hrbd_pkg::ST_SPAN: n_state = hrbd_pkg::ST_MUL;
            hrbd_pkg::ST_MUL: begin
                n_state = (r_span == '0) ? hrbd_pkg::ST_RES : hrbd_pkg::ST_DIV;
            end
            hrbd_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = hrbd_pkg::ST_RES;
                end
            end
            hrbd_pkg::ST_RES: n_state = hrbd_pkg::ST_OUT;
            hrbd_pkg::ST_OUT: begin
                if (ctrl.out_load) begin
                    n_state = hrbd_pkg::ST_IDLE;
                end
            end
            default: n_state = hrbd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (r_state)
            hrbd_pkg::ST_IDLE: ctrl.in_ready  = 1'b1;
            hrbd_pkg::ST_READ: ctrl.ram_re    = 1'b1;
            hrbd_pkg::ST_MUL:  ctrl.div_start = (r_span != '0);
            hrbd_pkg::ST_OUT:  ctrl.out_load  = !r_out_valid || i_m_axis_tready;
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hrbd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // beat detection state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot <= '0;
            r_fill       <= '0;
            r_last       <= '0;
            r_above      <= 1'b0;
        end else if (in_fire) begin
            r_above <= is_above;
            r_fill  <= fill_next;
            if (beat_ok) begin
                r_write_slot <= slot_next;
                r_last       <= in_now;
            end
        end
    end

    // rate datapath
    always_ff @(posedge i_clk) begin
        if (r_state == hrbd_pkg::ST_SPAN) begin
            r_span <= r_last - ram_q;
        end
        if (r_state == hrbd_pkg::ST_MUL) begin
            r_lo_prod <= r_lo * r_span;
            r_hi_prod <= r_hi * r_span;
        end
        if (in_fire) begin
            r_res_acc    <= beat_ok;
            r_res_valid  <= 1'b0;
            r_res_tenths <= '0;
            r_res_cls    <= hrbd_pkg::CLS_NORMAL;
        end else if (r_state == hrbd_pkg::ST_RES) begin
            r_res_valid  <= 1'b1;
            r_res_tenths <= tenths_sat;
            r_res_cls    <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led <= 2'b00;
        end else if (r_state == hrbd_pkg::ST_RES) begin
            r_led <= (cls == hrbd_pkg::CLS_NORMAL) ? 2'b01 : 2'b10;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out_data <= {6'd0, r_led[1], r_led[0], r_res_acc, r_res_cls,
                           r_res_tenths, r_res_valid};
        end
    end

    assign o_s_axis_tready = ctrl.in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // configuration
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= hrbd_pkg::THRESH_RST;
            r_refr   <= hrbd_pkg::REFR_RST;
            r_lo     <= hrbd_pkg::LO_RST;
            r_hi     <= hrbd_pkg::HI_RST;
        end else if (cfg_wr) begin
            unique case (hrbd_pkg::t_reg_idx'(i_paddr[3:2]))
                hrbd_pkg::REG_THRESH: r_thresh <= i_pwdata[hrbd_pkg::SAMPLE_W-1:0];
                hrbd_pkg::REG_REFR:   r_refr   <= i_pwdata[hrbd_pkg::REFR_W-1:0];
                hrbd_pkg::REG_LO:     r_lo     <= i_pwdata[hrbd_pkg::BOUND_W-1:0];
                hrbd_pkg::REG_HI:     r_hi     <= i_pwdata[hrbd_pkg::BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (hrbd_pkg::t_reg_idx'(i_paddr[3:2]))
            hrbd_pkg::REG_THRESH: o_prdata = {22'd0, r_thresh};
            hrbd_pkg::REG_REFR:   o_prdata = {16'd0, r_refr};
            hrbd_pkg::REG_LO:     o_prdata = {24'd0, r_lo};
            hrbd_pkg::REG_HI:     o_prdata = {24'd0, r_hi};
            default:              o_prdata = '0;
        endcase
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_slot < hrbd_pkg::SLOT_W'(hrbd_pkg::RING_BEATS))
        else $error("write slot out of range");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= hrbd_pkg::FILL_W'(hrbd_pkg::RING_BEATS))
        else $error("fill count out of range");

    a_led_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[0]) |-> (r_out_data[24] != r_out_data[25]))
        else $error("valid rate without exactly one LED");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data[0]) |-> (r_out_data[22:1] == '0))
        else $error("rate fields set without valid rate");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == hrbd_pkg::ST_DIV))
        else $error("divider finished outside divide state");

endmodule
